FILE: hw/rtl/ipv6_cidr_text_parser_assert.svh
// Assertion macros for the IPv6 CIDR text parser.
`ifndef IPV6_CIDR_TEXT_PARSER_ASSERT_SVH
`define IPV6_CIDR_TEXT_PARSER_ASSERT_SVH
// A condition that must hold in the cycle after a trigger.
`define ICP_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");
// A condition that must hold in the same cycle.
`define ICP_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/icp_pkg.sv
// Package with types and constants of the IPv6 CIDR text parser.
`default_nettype none
package icp_pkg;
    localparam int unsigned GROUPS = 8;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_HOST = 2'd3;
    localparam logic [1:0] CR_NONE = 2'd0;
    localparam logic [1:0] CR_ONE = 2'd1;
    localparam logic [1:0] CR_DOUBLE = 2'd2;
    localparam logic [1:0] CR_LEAD = 2'd3;

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic             in_prefix;
        logic [7:0][15:0] head;
        logic [7:0][15:0] tail;
        logic [3:0]       head_count;
        logic [3:0]       tail_count;
        logic             seen_comp;
        logic [1:0]       colon_run;
        logic [15:0]      hex_accum;
        logic [3:0]       token_chars;
        logic             token_dotted;
        logic             token_hexletter;
        logic [2:0][7:0]  quad;
        logic [8:0]       oct_value;
        logic [3:0]       oct_digits;
        logic [2:0]       quad_dots;
        logic             quad_wait;
        logic [33:0]      dec_accum;
        logic [3:0]       dec_digits;
        logic             body_error;
        logic             prefix_error;
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
    } t_result;
endpackage
`default_nettype wire

FILE: hw/rtl/icp_step.sv
// Next-state logic for one character of the text, and the result on the last one.
`default_nettype none
module icp_step (
    input  wire icp_pkg::t_state  i_st,
    input  wire logic [7:0]       i_ch,
    output icp_pkg::t_state       o_st,
    output icp_pkg::t_result      o_res
);
    icp_pkg::t_state s;
    logic [3:0] dig;
    logic is_dig, is_hex;
    logic [12:0] ov;
    logic [15:0] grp [0:7];
    logic [63:0] hi, lo, hm, lm;
    logic [33:0] p;
    logic [6:0] sh;
    logic [2:0] idx;
    integer i;

    // Push one group onto the side that is currently being filled.
    function automatic icp_pkg::t_state push(input icp_pkg::t_state a, input logic [15:0] g);
        icp_pkg::t_state b;
        b = a;
        if (a.seen_comp) begin
            if (a.tail_count >= 4'd8) b.body_error = 1'b1;
            else begin
                b.tail[a.tail_count[2:0]] = g;
                b.tail_count = a.tail_count + 4'd1;
            end
        end else begin
            if (a.head_count >= 4'd8) b.body_error = 1'b1;
            else begin
                b.head[a.head_count[2:0]] = g;
                b.head_count = a.head_count + 4'd1;
            end
        end
        return b;
    endfunction

    function automatic logic oct_ok(input icp_pkg::t_state a);
        return a.oct_digits >= 4'd1 && a.oct_digits <= 4'd10 && a.oct_value <= 9'd255;
    endfunction

    function automatic icp_pkg::t_state finish(input icp_pkg::t_state a, input logic at_colon);
        icp_pkg::t_state b;
        b = a;
        if (a.token_dotted) begin
            if (a.token_hexletter || a.quad_dots != 3'd3 || !oct_ok(a)) b.body_error = 1'b1;
            else begin
                b = push(b, {a.quad[0], a.quad[1]});
                b = push(b, {a.quad[2], a.oct_value[7:0]});
            end
            if (at_colon) begin
                if (a.seen_comp) b.body_error = 1'b1;
                else b.quad_wait = 1'b1;
            end
        end else if (a.token_chars > 4'd4) b.body_error = 1'b1;
        else b = push(b, a.hex_accum);
        b.hex_accum = '0; b.token_chars = '0; b.token_dotted = 1'b0;
        b.token_hexletter = 1'b0; b.quad_dots = '0; b.oct_value = '0;
        b.oct_digits = '0; b.quad = '0;
        return b;
    endfunction

    always_comb begin
        s = i_st;
        is_dig = i_ch >= 8'h30 && i_ch <= 8'h39;
        is_hex = (i_ch >= 8'h61 && i_ch <= 8'h66) || (i_ch >= 8'h41 && i_ch <= 8'h46);
        dig = is_dig ? 4'(i_ch - 8'h30) : (i_ch >= 8'h61 ? 4'(i_ch - 8'h57) : 4'(i_ch - 8'h37));
        ov = '0;
        if (i_st.in_prefix) begin
            if (is_dig) begin
                if (i_st.dec_digits < 4'd15) s.dec_digits = i_st.dec_digits + 4'd1;
                if (s.dec_digits <= 4'd10)
                    s.dec_accum = 34'(i_st.dec_accum * 34'd10) + 34'(dig);
            end else s.prefix_error = 1'b1;
        end else if (i_ch == 8'h2f) begin
            if (s.quad_wait) s.body_error = 1'b1;
            s.quad_wait = 1'b0;
            if (s.token_chars > 4'd0) s = finish(s, 1'b0);
            else if (s.colon_run == icp_pkg::CR_ONE || s.colon_run == icp_pkg::CR_LEAD)
                s.body_error = 1'b1;
            if (s.seen_comp) begin
                if (5'(s.head_count) + 5'(s.tail_count) >= 5'd8) s.body_error = 1'b1;
            end else if (s.head_count != 4'd8) s.body_error = 1'b1;
            s.in_prefix = 1'b1;
        end else begin
            if (s.quad_wait) begin
                s.quad_wait = 1'b0;
                if (i_ch != 8'h3a) s.body_error = 1'b1;
            end
            if (i_ch == 8'h3a) begin
                if (s.token_chars > 4'd0) begin
                    s = finish(s, 1'b1);
                    s.colon_run = icp_pkg::CR_ONE;
                end else if (s.colon_run == icp_pkg::CR_NONE) s.colon_run = icp_pkg::CR_LEAD;
                else if (s.colon_run == icp_pkg::CR_DOUBLE) s.body_error = 1'b1;
                else begin
                    if (s.seen_comp) s.body_error = 1'b1;
                    s.seen_comp = 1'b1;
                    s.colon_run = icp_pkg::CR_DOUBLE;
                end
            end else begin
                if (s.colon_run == icp_pkg::CR_LEAD) s.body_error = 1'b1;
                s.colon_run = icp_pkg::CR_NONE;
                if (s.token_chars < 4'd15) s.token_chars = s.token_chars + 4'd1;
                if (is_dig) begin
                    s.hex_accum = {s.hex_accum[11:0], dig};
                    if (s.oct_digits < 4'd15) s.oct_digits = s.oct_digits + 4'd1;
                    ov = 13'(s.oct_value) * 13'd10 + 13'(dig);
                    s.oct_value = (ov > 13'd256) ? 9'd256 : ov[8:0];
                end else if (is_hex) begin
                    s.hex_accum = {s.hex_accum[11:0], dig};
                    s.token_hexletter = 1'b1;
                end else if (i_ch == 8'h2e) begin
                    s.token_dotted = 1'b1;
                    if (!oct_ok(s) || s.quad_dots >= 3'd3) s.body_error = 1'b1;
                    else begin
                        s.quad[s.quad_dots[1:0]] = s.oct_value[7:0];
                        s.quad_dots = s.quad_dots + 3'd1;
                    end
                    s.oct_value = '0;
                    s.oct_digits = '0;
                end else s.body_error = 1'b1;
            end
        end
        o_st = s;

        // Assemble the address and check it against the prefix.
        idx = '0;
        for (i = 0; i < 8; i++) grp[i] = (i < s.head_count) ? s.head[i] : 16'd0;
        if (s.seen_comp)
            for (i = 0; i < 8; i++)
                if (i < s.tail_count) begin
                    idx = 3'(4'd8 - s.tail_count + 4'(i));
                    grp[idx] = s.tail[i];
                end
        hi = {grp[0], grp[1], grp[2], grp[3]};
        lo = {grp[4], grp[5], grp[6], grp[7]};
        p = s.dec_accum;
        sh = 7'(8'd64 - 8'(p[6:0]));
        hm = (p >= 34'd64) ? '1 : ((p == 34'd0) ? '0 : ('1 << sh));
        sh = 7'(8'd128 - 8'(p[7:0]));
        lm = (p <= 34'd64) ? '0 : ((p == 34'd128) ? '1 : ('1 << sh));
        o_res = '0;
        if (!s.in_prefix || s.prefix_error || s.dec_digits == 4'd0 || s.dec_digits > 4'd10
            || p > 34'hffffffff) o_res.status = icp_pkg::ST_FORMAT;
        else if (p > 34'd128) o_res.status = icp_pkg::ST_RANGE;
        else if (s.body_error) o_res.status = icp_pkg::ST_FORMAT;
        else if ((hi & ~hm) != 0 || (lo & ~lm) != 0) o_res.status = icp_pkg::ST_HOST;
        else begin
            o_res.status = icp_pkg::ST_OK;
            o_res.hi = hi;
            o_res.lo = lo;
            o_res.plen = p[7:0];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ipv6_cidr_text_parser.sv
// Top level of the IPv6 CIDR text parser.
// One character is taken per cycle; the result appears in an output register in the cycle
// after the character flagged last, and the next text may start at once. The parse state
// register and the incoming character feed short combinational logic whose result is
// captured in the result register. While a result waits and the receiver is not ready,
// no character is taken; otherwise one is taken in every cycle.
`default_nettype none
`include "ipv6_cidr_text_parser_assert.svh"
module ipv6_cidr_text_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_ch,
    input  wire         i_last,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_address_high,
    output logic [63:0] o_address_low,
    output logic [7:0]  o_prefix_length
);
    icp_pkg::t_state r_st, n_st;
    icp_pkg::t_result r_res, n_res;
    logic r_valid;
    logic acc;
    logic out_stall;
    logic out_not_ok;

    icp_step u_step (.i_st(r_st), .i_ch(i_ch), .o_st(n_st), .o_res(n_res));

    assign o_ready = !r_valid || i_ready;
    assign acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
            r_valid <= 1'b0;
        end else begin
            if (acc) r_st <= i_last ? '0 : n_st;
            if (acc && i_last) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_last) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_status = r_res.status;
    assign o_address_high = r_res.hi;
    assign o_address_low = r_res.lo;
    assign o_prefix_length = r_res.plen;

    assign out_stall = o_valid && !i_ready;
    assign out_not_ok = o_valid && o_status != icp_pkg::ST_OK;

    `ICP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, acc && i_last, o_valid)
    `ICP_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, out_stall, o_valid && $stable(o_status))
    `ICP_ASSERT_NOW(a_zero_unless_ok, i_clk, i_rst_n, out_not_ok, o_prefix_length == 8'd0)
endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the IPv6 CIDR text parser: random and directed CIDR texts against a predictor.
`timescale 1ns / 1ps
module tb;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_ch;
    logic        in_last;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  out_status;
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [7:0]  out_plen;

    ipv6_cidr_text_parser DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_ch(in_ch), .i_last(in_last),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_status(out_status), .o_address_high(out_hi), .o_address_low(out_lo),
        .o_prefix_length(out_plen)
    );

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    // A marker item that makes the driver hold off until all results are back.
    localparam logic [8:0] DRAIN_MARK = 9'h1ff;

    t_char            char_queue[$];
    logic             drain_flags[$];
    icp_pkg::t_result expected_results[$];
    int               error_count = 0;
    int               sent_count = 0;
    int               recv_count = 0;
    bit               calm_phase;

    // Predictor state.
    logic             p_in_prefix;
    logic [7:0][15:0] p_head;
    logic [7:0][15:0] p_tail;
    int               p_head_cnt, p_tail_cnt;
    logic             p_comp;
    logic [1:0]       p_colon;
    logic [15:0]      p_hex;
    int               p_tok_chars;
    logic             p_dotted, p_hexletter;
    logic [2:0][7:0]  p_quad;
    int               p_oct_val, p_oct_digits, p_dots;
    logic             p_quad_wait;
    logic [63:0]      p_dec;
    int               p_dec_digits;
    logic             p_body_err, p_prefix_err;

    function automatic void parser_clear_token();
        p_hex = '0; p_tok_chars = 0; p_dotted = 0; p_hexletter = 0;
        p_dots = 0; p_oct_val = 0; p_oct_digits = 0; p_quad = '0;
    endfunction

    function automatic void parser_reset();
        p_in_prefix = 0; p_head = '0; p_tail = '0; p_head_cnt = 0; p_tail_cnt = 0;
        p_comp = 0; p_colon = icp_pkg::CR_NONE; parser_clear_token(); p_quad_wait = 0;
        p_dec = '0; p_dec_digits = 0; p_body_err = 0; p_prefix_err = 0;
    endfunction

    function automatic bit octet_valid();
        return p_oct_digits >= 1 && p_oct_digits <= 10 && p_oct_val <= 255;
    endfunction

    function automatic void store_group(logic [15:0] g);
        if (p_comp) begin
            if (p_tail_cnt >= icp_pkg::GROUPS) p_body_err = 1;
            else begin
                p_tail[p_tail_cnt] = g;
                p_tail_cnt++;
            end
        end else begin
            if (p_head_cnt >= icp_pkg::GROUPS) p_body_err = 1;
            else begin
                p_head[p_head_cnt] = g;
                p_head_cnt++;
            end
        end
    endfunction

    function automatic void close_token(bit at_colon);
        if (p_dotted) begin
            if (p_hexletter || p_dots != 3 || !octet_valid()) p_body_err = 1;
            else begin
                store_group({p_quad[0], p_quad[1]});
                store_group({p_quad[2], p_oct_val[7:0]});
            end
            if (at_colon) begin
                if (p_comp) p_body_err = 1;
                else p_quad_wait = 1;
            end
        end else if (p_tok_chars > 4) begin
            p_body_err = 1;
        end else begin
            store_group(p_hex);
        end
        parser_clear_token();
    endfunction

    function automatic void address_char(logic [7:0] c);
        logic [3:0] nib;
        if (p_quad_wait) begin
            p_quad_wait = 0;
            if (c != ":") p_body_err = 1;
        end
        if (c == ":") begin
            if (p_tok_chars > 0) begin
                close_token(1);
                p_colon = icp_pkg::CR_ONE;
            end else if (p_colon == icp_pkg::CR_NONE) p_colon = icp_pkg::CR_LEAD;
            else if (p_colon == icp_pkg::CR_DOUBLE) p_body_err = 1;
            else begin
                if (p_comp) p_body_err = 1;
                p_comp = 1;
                p_colon = icp_pkg::CR_DOUBLE;
            end
            return;
        end
        if (p_colon == icp_pkg::CR_LEAD) p_body_err = 1;
        p_colon = icp_pkg::CR_NONE;
        if (p_tok_chars < 15) p_tok_chars++;
        if (c >= "0" && c <= "9") begin
            nib = 4'(c - 8'h30);
            p_hex = {p_hex[11:0], nib};
            if (p_oct_digits < 15) p_oct_digits++;
            p_oct_val = p_oct_val * 10 + nib;
            if (p_oct_val > 256) p_oct_val = 256;
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            nib = (c >= "a") ? 4'(c - 8'h57) : 4'(c - 8'h37);
            p_hex = {p_hex[11:0], nib};
            p_hexletter = 1;
        end else if (c == ".") begin
            p_dotted = 1;
            if (!octet_valid() || p_dots >= 3) p_body_err = 1;
            else begin
                p_quad[p_dots] = p_oct_val[7:0];
                p_dots++;
            end
            p_oct_val = 0; p_oct_digits = 0;
        end else begin
            p_body_err = 1;
        end
    endfunction

    function automatic void address_end();
        if (p_quad_wait) p_body_err = 1;
        p_quad_wait = 0;
        if (p_tok_chars > 0) close_token(0);
        else if (p_colon == icp_pkg::CR_ONE || p_colon == icp_pkg::CR_LEAD) p_body_err = 1;
        if (p_comp) begin
            if (p_head_cnt + p_tail_cnt >= icp_pkg::GROUPS) p_body_err = 1;
        end else if (p_head_cnt != icp_pkg::GROUPS) p_body_err = 1;
    endfunction

    // Advances the predictor by one character; returns 1 with a result on the last one.
    function automatic bit parse_char(t_char it, output icp_pkg::t_result r);
        logic [7:0][15:0] g;
        logic [127:0] addr, host_mask;
        r = '0;
        if (p_in_prefix) begin
            if (it.ch >= "0" && it.ch <= "9") begin
                if (p_dec_digits < 15) p_dec_digits++;
                if (p_dec_digits <= 10) p_dec = p_dec * 10 + 64'(it.ch - 8'h30);
            end else p_prefix_err = 1;
        end else if (it.ch == "/") begin
            address_end();
            p_in_prefix = 1;
        end else address_char(it.ch);
        if (!it.last) return 0;
        if (!p_in_prefix || p_prefix_err || p_dec_digits == 0 || p_dec_digits > 10
                || p_dec > 64'hffff_ffff) r.status = icp_pkg::ST_FORMAT;
        else if (p_dec > 128) r.status = icp_pkg::ST_RANGE;
        else if (p_body_err) r.status = icp_pkg::ST_FORMAT;
        else begin
            g = '0;
            for (int i = 0; i < p_head_cnt; i++) g[7 - i] = p_head[i];
            if (p_comp)
                for (int i = 0; i < p_tail_cnt; i++) g[7 - ((8 - p_tail_cnt + i) & 7)] = p_tail[i];
            addr = g;
            host_mask = (p_dec == 128) ? '0 : ({128{1'b1}} >> p_dec);
            if ((addr & host_mask) != 0) r.status = icp_pkg::ST_HOST;
            else begin
                r.status = icp_pkg::ST_OK;
                r.hi = addr[127:64];
                r.lo = addr[63:0];
                r.plen = p_dec[7:0];
            end
        end
        parser_reset();
        return 1;
    endfunction

    task automatic queue_text(string s);
        t_char            it;
        icp_pkg::t_result r;
        for (int i = 0; i < s.len(); i++) begin
            it.ch = s[i];
            it.last = (i == s.len() - 1);
            char_queue = {char_queue, it};
            drain_flags = {drain_flags, 1'b0};
            if (parse_char(it, r)) expected_results = {expected_results, r};
        end
    endtask

    task automatic queue_drain();
        char_queue = {char_queue, t_char'(DRAIN_MARK)};
        drain_flags = {drain_flags, 1'b1};
    endtask

    function automatic string hex_group(int n);
        string s = "";
        string digs = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++) begin
            s = {s, " "};
            s[s.len() - 1] = digs[$urandom_range(0, 21)];
        end
        return s;
    endfunction

    function automatic string small_group();
        case ($urandom_range(0, 3))
            0: return "0";
            1: return "00";
            default: return hex_group($urandom_range(1, 4));
        endcase
    endfunction

    function automatic string quad_text();
        return $sformatf("%0d.%0d.%0d.%0d", $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    function automatic string plen_text();
        case ($urandom_range(0, 9))
            0: return $sformatf("%0d", $urandom_range(129, 100000));
            1: return $sformatf("%0d", $urandom());
            2: return $sformatf("%010d", $urandom_range(0, 128));
            3: return "";
            4: return "99999999999";
            default: return $sformatf("%0d", $urandom_range(0, 128));
        endcase
    endfunction

    // A well-formed address body, with compression and a dotted quad at random.
    function automatic string address_text();
        string s = "";
        int total = $urandom_range(0, 1) ? 8 : $urandom_range(0, 7);
        int cut = $urandom_range(0, total);
        bit comp = (total < 8);
        bit quad_end = $urandom_range(0, 3) == 0 && total >= 2;
        int n_groups = quad_end ? total - 2 : total;
        if (comp && cut > n_groups) cut = n_groups;
        for (int i = 0; i < n_groups; i++) begin
            if (comp && i == cut) s = {s, "::"};
            else if (i > 0) s = {s, ":"};
            s = {s, small_group()};
        end
        if (quad_end) s = {s, (comp && cut == n_groups) ? "::" : (n_groups > 0 ? ":" : ""),
                          quad_text()};
        else if (comp && cut == n_groups) s = {s, "::"};
        if (!comp && quad_end && n_groups == 0) s = quad_text();
        return s;
    endfunction

    // Replaces a character of a text with a random noise character.
    function automatic string corrupt(string s);
        string noise = ":/.gG9fx: ";
        int pos;
        logic [7:0] c;
        if (s.len() == 0) return s;
        pos = $urandom_range(0, s.len() - 1);
        c = $urandom_range(0, 1) ? noise[$urandom_range(0, 9)] : 8'($urandom_range(0, 255));
        s[pos] = c;
        return s;
    endfunction

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial begin
        #200_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender side.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_ch <= '0;
            in_last <= 0;
        end else begin
            if (in_valid && in_ready) begin
                void'(char_queue.pop_front());
                void'(drain_flags.pop_front());
                if (in_last) sent_count <= sent_count + 1;
            end
            while (drain_flags.size() > 0 && drain_flags[0] && sent_count == recv_count
                   && !(in_valid && in_ready && in_last)) begin
                void'(char_queue.pop_front());
                void'(drain_flags.pop_front());
            end
            if (in_valid && !in_ready) begin
                // Hold the item until it is taken.
            end else if (char_queue.size() > 0 && !drain_flags[0]
                         && (calm_phase || $urandom_range(0, 99) >= 26)) begin
                in_valid <= 1;
                in_ch <= char_queue[0].ch;
                in_last <= char_queue[0].last;
            end else begin
                in_valid <= 0;
            end
        end
    end

    // Receiver side and checking.
    always @(posedge clk) begin
        icp_pkg::t_result exp_r;
        if (!rst_n) begin
            out_ready <= 0;
        end else begin
            out_ready <= calm_phase || $urandom_range(0, 99) >= 26;
            if (out_valid && out_ready) begin
                recv_count <= recv_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result with none expected");
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, out_status);
                        error_count++;
                    end
                    if (out_hi !== exp_r.hi) begin
                        $error("address_high: expected %h, actual %h", exp_r.hi, out_hi);
                        error_count++;
                    end
                    if (out_lo !== exp_r.lo) begin
                        $error("address_low: expected %h, actual %h", exp_r.lo, out_lo);
                        error_count++;
                    end
                    if (out_plen !== exp_r.plen) begin
                        $error("prefix_length: expected %0d, actual %0d", exp_r.plen, out_plen);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        string s;
        int guard;
        calm_phase = 0;
        rst_n = 0;
        parser_reset();

        queue_text("::/0");
        queue_text("ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff/128");
        queue_text("2001:db8::/32");
        queue_text("::ffff:192.168.1.0/120");
        queue_text("1.2.3.4::/32");
        queue_text("1:2:3:4:5:6:255.255.255.255/128");
        queue_text("1::/0");
        queue_text("::/129");
        queue_text(":::/0");
        queue_text("1::2::/64");
        queue_text("12345::/16");
        queue_text("::/4294967295");
        queue_text("::/4294967296");
        queue_text(":1::/16");
        queue_text("::");
        queue_text("::/");
        queue_text("::/1/");
        queue_text("x::/300");
        queue_text("1:2:3:4:5:6:7::/64");
        queue_text("1.2.3.4:5::/64");
        queue_text("::256.1.1.1/64");
        queue_text("/");
        queue_text(string'({"::/", 8'h80}));
        queue_drain();

        for (int n = 0; char_queue.size() < 1500; n++) begin
            s = {address_text(), "/", plen_text()};
            if ($urandom_range(0, 4) == 0) s = corrupt(s);
            if ($urandom_range(0, 19) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
            if (s.len() == 0) s = "/";
            queue_text(s);
            if (n % 40 == 39) queue_drain();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1;
        guard = 0;
        while (char_queue.size() > 0) begin
            @(posedge clk);
            guard++;
            calm_phase <= (guard >= 600 && guard < 1000);
        end
        while (expected_results.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/icp_pkg.sv
hw/rtl/icp_step.sv
hw/rtl/ipv6_cidr_text_parser.sv
test/tb.sv
